// ===== src/sjb_pkg.sv =====
// Shared types, field widths and codes for the sequence-number jitter buffer.
`timescale 1ns / 1ps
package sjb_pkg;

  // Field widths fixed by the interface
  localparam int SEQ_W    = 16;
  localparam int HANDLE_W = 32;
  localparam int LEN_W    = 16;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 4;
  localparam int OP_W     = 2;
  localparam int DIST_W   = SEQ_W + 1;

  // Default table size and register reset value
  localparam int CAPACITY_DEF = 16;
  localparam logic [FILL_W-1:0] MIN_FRAMES_RST = FILL_W'(3);

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_STORED  = 4'd0;
  localparam logic [STATUS_W-1:0] ST_LATE    = 4'd1;
  localparam logic [STATUS_W-1:0] ST_DUP     = 4'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 4'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_POPPED  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_WAITING = 4'd7;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 4'd8;

  // Distance that no held entry can reach
  localparam logic [DIST_W-1:0] DIST_NONE = {1'b1, {SEQ_W{1'b0}}};

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] frame_handle;
    logic [LEN_W-1:0]    frame_length;
    logic                require_min;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    out_seq;
    logic [HANDLE_W-1:0] out_handle;
    logic [LEN_W-1:0]    out_length;
    logic [FILL_W-1:0]   fill_count;
  } result_t;

  // Control for the shared distance and compare unit
  typedef struct packed {
    logic             start;
    logic             en;
    logic             entry_valid;
    logic [SEQ_W-1:0] entry_seq;
    logic [SEQ_W-1:0] base;
  } scan_ctl_t;

endpackage

// ===== src/seq_jitter_buffer_core.sv =====
// Top level of the sequence-number jitter buffer: sequencer, valid bits and entry storage.
//
// Usage: items (push, pop or clear) enter on the item channel, qualified by
// item_valid and taken at an edge where item_stall is low. Each item gives
// exactly one transaction on the result channel, held in an output register
// until result_stall is low. One write on the cfg channel sets the minimum
// number of buffered frames; cfg_ready is always high.
// Timing: one item at a time. Empty, late, clear and underfilled decisions
// pass from acceptance through S_CHECK and S_RESP to the output register.
// Push and pop scan every table entry through the shared compare unit, one
// entry per cycle from the sequence-number RAM, then pass through S_EVAL;
// a pop that delivers a frame also reads the payload RAM in S_FETCH.
// The scan over CAPACITY entries sets the throughput: the next item is taken
// in the cycle after the previous result enters the output register.
// Reset: the table is empty, the expected number unknown, the register 3.
// The entry RAMs are not cleared; per-entry valid bits guard them.
// A stalled result does not block acceptance of the next item, but that
// item's result waits until the output register is free.
`timescale 1ns / 1ps
module seq_jitter_buffer_core #(
  parameter int CAPACITY = sjb_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  sjb_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output sjb_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sjb_pkg::FILL_W-1:0] cfg_data
);
  import sjb_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > FILL_W + 1) ? CNT_W : FILL_W + 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]              state;
  item_t                   cur;
  result_t                 rsp;
  logic [FILL_W-1:0]       min_frames;
  logic [CAPACITY-1:0]     entry_valid;
  logic [CNT_W-1:0]        held;
  logic [SEQ_W-1:0]        expected;
  logic                    known;
  logic [CNT_W-1:0]        scan_cnt;
  logic                    chk_en;
  logic [IDX_W-1:0]        chk_idx;

  scan_ctl_t               scan_ctl;
  logic [DIST_W-1:0]       best_dist;
  logic [IDX_W-1:0]        best_idx;
  logic [SEQ_W-1:0]        best_seq;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;

  logic [SEQ_W-1:0]        seq_rdata;
  logic [HANDLE_W+LEN_W-1:0] data_rdata;
  logic                    store_we;

  logic [SEQ_W-1:0]        behind;
  logic                    is_late;
  logic                    underfilled;
  logic [1:0]              window;
  logic                    must_wait;
  logic                    scan_issue;
  logic                    out_free;
  logic                    out_load;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;
  assign out_load   = (state == S_RESP) && out_free;

  // Late push: 1 to 32767 behind the expected number.
  assign behind  = expected - cur.seq;
  assign is_late = known && (behind != '0) && !behind[SEQ_W-1];

  // Pop refused while the table is empty or, with require_min set, below the minimum fill.
  assign underfilled = (held == '0) ||
                       (cur.require_min && (CMP_W'(held) < CMP_W'(min_frames)));

  // Wait window max(1, min(2, min/3)) reduces to 2 from six frames up, else 1.
  assign window    = (min_frames >= FILL_W'(6)) ? 2'd2 : 2'd1;
  assign must_wait = cur.require_min && known &&
                     (best_dist <= DIST_W'(window)) &&
                     (CMP_W'(held) < (CMP_W'(min_frames) + CMP_W'(window)));

  // Scan drives the shared unit one entry per cycle from the registered RAM read.
  assign scan_issue        = (state == S_SCAN) && (scan_cnt < CAP_CNT);
  assign scan_ctl.start    = (state == S_CHECK);
  assign scan_ctl.en       = (state == S_SCAN) && chk_en;
  assign scan_ctl.entry_valid = entry_valid[chk_idx];
  assign scan_ctl.entry_seq   = seq_rdata;
  assign scan_ctl.base     = (cur.opcode == OP_PUSH) ? cur.seq :
                             (known ? expected : '0);

  // A stored push writes both RAMs at the first free slot.
  assign store_we = (state == S_EVAL) && (cur.opcode == OP_PUSH) &&
                    (best_dist != '0) && free_found;

  sjb_scan #(.IDX_W(IDX_W)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .idx        (chk_idx),
    .best_dist  (best_dist),
    .best_idx   (best_idx),
    .best_seq   (best_seq),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  sjb_ram #(.WIDTH(SEQ_W), .DEPTH(CAPACITY)) u_seq_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (free_idx),
    .wdata (cur.seq),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (seq_rdata)
  );

  sjb_ram #(.WIDTH(HANDLE_W + LEN_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (free_idx),
    .wdata ({cur.frame_handle, cur.frame_length}),
    .raddr (best_idx),
    .rdata (data_rdata)
  );

  // Item capture.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      cur <= item;
    end
  end

  // Sequencer, table bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      min_frames   <= MIN_FRAMES_RST;
      entry_valid  <= '0;
      held         <= '0;
      expected     <= '0;
      known        <= 1'b0;
      scan_cnt     <= '0;
      chk_en       <= 1'b0;
      chk_idx      <= '0;
      rsp          <= '0;
      result       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_frames <= cfg_data;
      end

      // The output register fills from the sequencer and empties on acceptance.
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            rsp   <= '0;
            state <= S_CHECK;
          end
        end

        // Decisions that need no scan.
        S_CHECK: begin
          scan_cnt <= '0;
          chk_en   <= 1'b0;
          case (cur.opcode)
            OP_PUSH: begin
              if (cur.frame_length == '0) begin
                rsp.status <= ST_EMPTY;
                state      <= S_RESP;
              end else if (is_late) begin
                rsp.status <= ST_LATE;
                state      <= S_RESP;
              end else begin
                state <= S_SCAN;
              end
            end
            OP_POP: begin
              if (underfilled) begin
                rsp.status <= ST_UNDER;
                state      <= S_RESP;
              end else begin
                state <= S_SCAN;
              end
            end
            OP_CLEAR: begin
              entry_valid <= '0;
              held        <= '0;
              expected    <= '0;
              known       <= 1'b0;
              rsp.status  <= ST_CLEARED;
              state       <= S_RESP;
            end
            default: begin
              rsp.status <= ST_UNDER;
              state      <= S_RESP;
            end
          endcase
        end

        // Read every entry; the compare runs in the cycle after the read.
        S_SCAN: begin
          chk_en  <= scan_issue;
          chk_idx <= scan_cnt[IDX_W-1:0];
          if (scan_issue) begin
            scan_cnt <= scan_cnt + 1'b1;
          end else if (!chk_en) begin
            state <= S_EVAL;
          end
        end

        // Act on the nearest entry and the first free slot.
        S_EVAL: begin
          if (cur.opcode == OP_PUSH) begin
            if (best_dist == '0) begin
              rsp.status <= ST_DUP;
            end else if (held == CAP_CNT) begin
              rsp.status <= ST_FULL;
            end else begin
              entry_valid[free_idx] <= 1'b1;
              held                  <= held + 1'b1;
              if (!known) begin
                expected <= cur.seq;
                known    <= 1'b1;
              end
              rsp.status <= ST_STORED;
            end
            state <= S_RESP;
          end else if (best_dist == DIST_NONE) begin
            rsp.status <= ST_UNDER;
            state      <= S_RESP;
          end else if ((best_dist != '0) && must_wait) begin
            rsp.status <= ST_WAITING;
            state      <= S_RESP;
          end else begin
            state <= S_FETCH;
          end
        end

        // Payload RAM data for the chosen entry is ready; deliver it.
        S_FETCH: begin
          rsp.status            <= ST_POPPED;
          rsp.out_seq           <= best_seq;
          rsp.out_handle        <= data_rdata[HANDLE_W+LEN_W-1:LEN_W];
          rsp.out_length        <= data_rdata[LEN_W-1:0];
          entry_valid[best_idx] <= 1'b0;
          held                  <= held - 1'b1;
          expected              <= best_seq + 1'b1;
          known                 <= 1'b1;
          state                 <= S_RESP;
        end

        // Hand the result to the output register once it is free.
        S_RESP: begin
          if (out_free) begin
            result <= {rsp.status, rsp.out_seq, rsp.out_handle, rsp.out_length,
                       FILL_W'(held)};
            state  <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/sjb_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
module sjb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sjb_scan.sv =====
// Shared forward-distance and compare unit that tracks the nearest entry and the first free slot.
`timescale 1ns / 1ps
module sjb_scan #(
  parameter int IDX_W = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sjb_pkg::scan_ctl_t        ctl,
  input  logic [IDX_W-1:0]          idx,
  output logic [sjb_pkg::DIST_W-1:0] best_dist,
  output logic [IDX_W-1:0]          best_idx,
  output logic [sjb_pkg::SEQ_W-1:0] best_seq,
  output logic                      free_found,
  output logic [IDX_W-1:0]          free_idx
);
  import sjb_pkg::*;

  logic [DIST_W-1:0] fwd_dist;

  // Forward distance from the base number, modulo 2^16.
  assign fwd_dist = {1'b0, ctl.entry_seq - ctl.base};

  // Keep the first entry at the least distance and the first empty slot seen.
  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      best_dist  <= DIST_NONE;
      free_found <= 1'b0;
    end else if (ctl.en) begin
      if (ctl.entry_valid && (fwd_dist < best_dist)) begin
        best_dist <= fwd_dist;
        best_idx  <= idx;
        best_seq  <= ctl.entry_seq;
      end
      if (!ctl.entry_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
    end
  end

endmodule

// ===== verif/seq_jitter_buffer_core_tb.sv =====
// Self-checking testbench for the jitter buffer core: directed cases, then randomised phases.
`timescale 1ns / 1ps
module seq_jitter_buffer_core_tb;
  import sjb_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 5;
  localparam int SLOTS          = CAPACITY_DEF;
  localparam int IDLE_PCT       = 14;
  localparam int SETTLE_CYCLES  = CAPACITY_DEF + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 115;
  localparam int PHASES         = 10;
  localparam int QUIET_PHASE    = 3;
  localparam int MAX_PRINTS     = 60;

  // The one opcode that the package leaves without a name.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Register setting and share of pushes for each random phase.
  localparam logic [FILL_W-1:0] PHASE_MIN [PHASES] = '{5'd0, 5'd16, 5'd1, 5'd5, 5'd2,
                                                         5'd9, 5'd15, 5'd4, 5'd6, 5'd3};
  localparam int PHASE_PUSH [PHASES] = '{50, 72, 45, 55, 50, 60, 70, 48, 52, 55};

  // Mirrors the reorder table and checks results in order of acceptance.
  class jitter_scoreboard;
    bit                  slot_used [SLOTS];
    logic [SEQ_W-1:0]    slot_seq [SLOTS];
    logic [HANDLE_W-1:0] slot_handle [SLOTS];
    logic [LEN_W-1:0]    slot_len [SLOTS];
    logic [SEQ_W-1:0]    next_seq;
    bit                  next_known;
    int unsigned         held;
    int unsigned         min_frames;
    result_t             pending_results [$];
    int                  errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      next_seq   = '0;
      next_known = 1'b0;
      held       = 0;
      min_frames = MIN_FRAMES_RST;
      errors     = 0;
    endfunction

    function void set_min_frames(logic [FILL_W-1:0] value);
      min_frames = value;
    endfunction

    function int find_slot(logic [SEQ_W-1:0] s);
      foreach (slot_used[i]) begin
        if (slot_used[i] && slot_seq[i] == s) return i;
      end
      return -1;
    endfunction

    // Pushes are checked for empty, late, duplicate and full, in that order.
    function logic [STATUS_W-1:0] push_frame(item_t it);
      logic [SEQ_W-1:0] behind;
      int free_idx;
      free_idx = -1;
      if (it.frame_length == '0) return ST_EMPTY;
      if (next_known) begin
        behind = next_seq - it.seq;
        if (behind != '0 && !behind[SEQ_W-1]) return ST_LATE;
      end
      if (find_slot(it.seq) >= 0) return ST_DUP;
      if (held >= SLOTS) return ST_FULL;
      foreach (slot_used[i]) begin
        if (!slot_used[i] && free_idx < 0) free_idx = i;
      end
      slot_used[free_idx]   = 1'b1;
      slot_seq[free_idx]    = it.seq;
      slot_handle[free_idx] = it.frame_handle;
      slot_len[free_idx]    = it.frame_length;
      held++;
      if (!next_known) begin
        next_seq   = it.seq;
        next_known = 1'b1;
      end
      return ST_STORED;
    endfunction

    // A pop takes the expected frame, else the nearest one ahead unless it must wait.
    function result_t pop_frame(bit want_min);
      result_t          r;
      int               idx;
      int unsigned      best_gap;
      int unsigned      window;
      logic [SEQ_W:0]   lowest;
      logic [SEQ_W-1:0] gap;
      r = '0;
      if ((want_min && held < min_frames) || held == 0) begin
        r.status = ST_UNDER;
        return r;
      end
      if (!next_known) begin
        lowest = DIST_NONE;
        foreach (slot_used[i]) begin
          if (slot_used[i] && slot_seq[i] < lowest) lowest = {1'b0, slot_seq[i]};
        end
        next_seq   = lowest[SEQ_W-1:0];
        next_known = 1'b1;
      end
      idx = find_slot(next_seq);
      if (idx < 0) begin
        best_gap = 32'h1_0000;
        foreach (slot_used[i]) begin
          if (slot_used[i]) begin
            gap = slot_seq[i] - next_seq;
            if (32'(gap) < best_gap) begin
              best_gap = 32'(gap);
              idx      = i;
            end
          end
        end
        window = min_frames / 3;
        if (window > 2) window = 2;
        if (window < 1) window = 1;
        if (want_min && best_gap <= window && held < min_frames + window) begin
          r.status = ST_WAITING;
          return r;
        end
      end
      r.status      = ST_POPPED;
      r.out_seq     = slot_seq[idx];
      r.out_handle  = slot_handle[idx];
      r.out_length  = slot_len[idx];
      slot_used[idx] = 1'b0;
      held--;
      next_seq   = slot_seq[idx] + 1'b1;
      next_known = 1'b1;
      return r;
    endfunction

    function result_t table_outcome(item_t it);
      result_t r;
      r = '0;
      if (it.opcode == OP_PUSH) begin
        r.status = push_frame(it);
      end else if (it.opcode == OP_POP) begin
        r = pop_frame(it.require_min);
      end else if (it.opcode == OP_CLEAR) begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        held       = 0;
        next_seq   = '0;
        next_known = 1'b0;
        r.status   = ST_CLEARED;
      end else begin
        r.status = ST_UNDER;
      end
      r.fill_count = FILL_W'(held);
      return r;
    endfunction

    function void note_item(item_t it);
      pending_results.push_back(table_outcome(it));
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result transaction with nothing outstanding, status %0d", got.status));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.out_seq !== want.out_seq)
        report($sformatf("out_seq %h, expected %h", got.out_seq, want.out_seq));
      if (got.out_handle !== want.out_handle)
        report($sformatf("out_handle %h, expected %h", got.out_handle, want.out_handle));
      if (got.out_length !== want.out_length)
        report($sformatf("out_length %h, expected %h", got.out_length, want.out_length));
      if (got.fill_count !== want.fill_count)
        report($sformatf("fill_count %0d, expected %0d", got.fill_count, want.fill_count));
    endtask
  endclass

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  item_t              item         = '0;
  logic               result_stall = 1'b0;
  logic               cfg_valid    = 1'b0;
  logic [FILL_W-1:0]  cfg_data     = '0;
  logic               idle_on      = 1'b1;
  logic               item_stall;
  logic               result_valid;
  result_t            result;
  logic               cfg_ready;
  int                 quiet_cycles = 0;
  logic [SEQ_W-1:0]   stream_seq;
  logic [SEQ_W-1:0]   last_pushed;
  jitter_scoreboard   board;

  seq_jitter_buffer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Random back-pressure on the result channel.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Each accepted result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      board.check_result(result);
    end
  end

  // The run ends if no transaction of any kind is accepted for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, with random idle cycles ahead of it, and waits until it is taken.
  task automatic send_item(input item_t it);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_item(it);
  endtask

  task automatic drive_op(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] s,
                          input logic [HANDLE_W-1:0] h, input logic [LEN_W-1:0] len,
                          input logic req);
    item_t it;
    it.opcode       = op;
    it.seq          = s;
    it.frame_handle = h;
    it.frame_length = len;
    it.require_min  = req;
    send_item(it);
  endtask

  // Waits for every outstanding result, then for the block to go quiet.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_frames(input logic [FILL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_min_frames(value);
  endtask

  // Mostly a forward stream with small reordering, plus duplicates, late frames and jumps.
  task automatic random_phase(input int count, input int push_pct);
    item_t it;
    int    pick;
    for (int n = 0; n < count; n++) begin
      it.seq          = SEQ_W'($urandom());
      it.frame_handle = $urandom();
      it.frame_length = LEN_W'($urandom());
      it.require_min  = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < push_pct) begin
        it.opcode = OP_PUSH;
        pick = $urandom_range(99);
        if (pick < 72) begin
          it.seq     = stream_seq + SEQ_W'($urandom_range(4));
          stream_seq = stream_seq + 1'b1;
        end else if (pick < 80) begin
          it.seq = last_pushed;
        end else if (pick < 88) begin
          it.seq = stream_seq - SEQ_W'($urandom_range(40, 5));
        end else if (pick >= 94) begin
          stream_seq = stream_seq + SEQ_W'($urandom_range(40000, 100));
          it.seq     = stream_seq;
        end
        pick = $urandom_range(99);
        if (pick < 5) begin
          it.frame_length = '0;
        end else if (pick < 8) begin
          it.frame_length = '1;
        end else if (it.frame_length == '0) begin
          it.frame_length = LEN_W'(1);
        end
        last_pushed = it.seq;
      end else if (pick < 97) begin
        it.opcode = OP_POP;
      end else if (pick < 99) begin
        it.opcode = OP_CLEAR;
      end else begin
        it.opcode = OP_UNUSED;
      end
      send_item(it);
    end
  endtask

  initial begin
    board       = new();
    stream_seq  = SEQ_W'($urandom());
    last_pushed = stream_seq;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases with the register at its reset value of three.
    drive_op(OP_POP,    16'h0000, 32'h0000_0000, 16'h0000, 1'b0); // pop from an empty table
    drive_op(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1); // unused opcode
    drive_op(OP_CLEAR,  16'h0000, 32'h0000_0000, 16'h0000, 1'b0); // clear when already empty
    drive_op(OP_PUSH,   16'h1111, 32'h1234_5678, 16'h0000, 1'b0); // empty frame
    drive_op(OP_PUSH,   16'hFFFE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0); // first frame sets expected
    drive_op(OP_PUSH,   16'hFFFF, 32'h0000_0000, 16'h0001, 1'b0);
    drive_op(OP_PUSH,   16'h0001, 32'h5A5A_5A5A, 16'h00FF, 1'b1); // across the wrap
    drive_op(OP_PUSH,   16'hFFFE, 32'hA5A5_A5A5, 16'h0005, 1'b0); // duplicate
    drive_op(OP_PUSH,   16'h7FFE, 32'h0F0F_0F0F, 16'h8000, 1'b0); // exactly half away: kept
    drive_op(OP_PUSH,   16'h7FFF, 32'hF0F0_F0F0, 16'h7FFF, 1'b0); // just under half behind: late
    drive_op(OP_PUSH,   16'h0005, 32'h8000_0001, 16'h0010, 1'b0);
    drive_op(OP_POP,    16'h0000, 32'h0000_0000, 16'h0000, 1'b1); // expected frame present
    drive_op(OP_POP,    16'h0000, 32'h0000_0000, 16'h0000, 1'b1);
    drive_op(OP_POP,    16'h0000, 32'h0000_0000, 16'h0000, 1'b1); // gap inside window: waits
    drive_op(OP_POP,    16'h0000, 32'h0000_0000, 16'h0000, 1'b0); // skips the gap
    drive_op(OP_POP,    16'h0000, 32'h0000_0000, 16'h0000, 1'b1); // below the minimum fill
    drive_op(OP_POP,    16'h0000, 32'h0000_0000, 16'h0000, 1'b0); // nearest frame ahead
    drive_op(OP_POP,    16'h0000, 32'h0000_0000, 16'h0000, 1'b0);
    drive_op(OP_POP,    16'h0000, 32'h0000_0000, 16'h0000, 1'b0); // empty again
    drive_op(OP_PUSH,   16'h8000, 32'h3C3C_3C3C, 16'h7FFF, 1'b1);
    drive_op(OP_CLEAR,  16'h0000, 32'h0000_0000, 16'h0000, 1'b0); // clear with a frame held
    drive_op(OP_PUSH,   16'h0100, 32'hC3C3_C3C3, 16'h00AA, 1'b0); // expected forgotten by clear
    drive_op(OP_POP,    16'h0000, 32'h0000_0000, 16'h0000, 1'b0);

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_min_frames(PHASE_MIN[p]);
      idle_on <= (p != QUIET_PHASE);
      random_phase(PHASE_ITEMS, PHASE_PUSH[p]);
    end
    settle();

    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
